// ===== rtl/mpsp_pkg.sv =====
// Shared types and constants of the MPEG program stream packetizer.
`timescale 1ns / 1ps
`default_nettype none

package mpsp_pkg;

    // header geometry
    localparam int HDR_BYTES = 64;
    localparam int HDR_IDX_W = $clog2(HDR_BYTES);
    localparam logic [HDR_IDX_W-1:0] HDR_LAST = HDR_IDX_W'(HDR_BYTES - 1);

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_RATE  = 2'd0,
        CFG_STUFF = 2'd1,
        CFG_CRC   = 2'd2
    } t_cfg_reg;

    // input word kinds (carried in tuser)
    localparam logic OP_START   = 1'b0;
    localparam logic OP_PAYLOAD = 1'b1;

    // field widths
    localparam int RATE_W = 18;
    localparam int MUX_W  = 22;
    localparam int SCR_W  = 33;
    localparam int LEN_W  = 16;
    localparam int REM_W  = 17;

    // SCR/PTS scale: 90 kHz ticks per millisecond
    localparam logic [6:0] SCR_MUL = 7'd90;

    // mux rate = ceil(rate * 1024 / 50); the divide by 50 is a reciprocal multiply,
    // exact for numerators below 2^28
    localparam int           MUX_NUM_W  = RATE_W + 10;
    localparam logic [MUX_NUM_W-1:0] MUX_ROUND = MUX_NUM_W'(49);
    localparam int           MUX_RECIP_W = 29;
    localparam logic [MUX_RECIP_W-1:0] MUX_RECIP = 29'd343597384;
    localparam int           MUX_SHIFT  = 34;

    // PES length field counts the 14 header bytes after it
    localparam logic [LEN_W-1:0] PES_LEN_ADJ = 16'd14;

    // fixed header bytes
    localparam logic [7:0] START_PREFIX = 8'h01;
    localparam logic [7:0] PACK_ID      = 8'hBA;
    localparam logic [7:0] MAP_ID       = 8'hBC;
    localparam logic [7:0] VIDEO_ID     = 8'hE0;
    localparam logic [7:0] AUDIO_ID     = 8'hC0;
    localparam logic [7:0] PES_FLAGS1   = 8'h8C;
    localparam logic [7:0] PES_FLAGS2   = 8'h80;
    localparam logic [7:0] PES_HDR_LEN  = 8'h0B;
    localparam logic [7:0] STUFF_LEN    = 8'hFE;
    localparam logic [7:0] FILL_FF      = 8'hFF;
    localparam logic [7:0] PES_TAIL     = 8'hF8;
    localparam logic [7:0] MARKER_ONE   = 8'h01;
    localparam logic [7:0] MAP_LEN_LO   = 8'h12;
    localparam logic [7:0] MAP_VER      = 8'hE6;
    localparam logic [7:0] MAP_INFO_LO  = 8'h08;
    localparam logic [7:0] MAP_ES_H264  = 8'h1B;
    localparam logic [7:0] MAP_ES_AAC   = 8'h0F;

    // per-frame header context, latched from a start word
    typedef struct packed {
        logic [SCR_W-1:0] t;
        logic [LEN_W-1:0] plen;
        logic             audio;
    } t_hdr_ctx;

    // register-derived header fields
    typedef struct packed {
        logic [MUX_W-1:0] mux;
        logic [31:0]      stuff;
        logic [31:0]      crc;
    } t_hdr_cfg;

endpackage

`default_nettype wire

// ===== rtl/mpsp_hdr_gen.sv =====
// Header byte selector: returns packet header byte number i_idx.
`timescale 1ns / 1ps
`default_nettype none

module mpsp_hdr_gen (
    input  wire [mpsp_pkg::HDR_IDX_W-1:0] i_idx,
    input  wire mpsp_pkg::t_hdr_ctx       i_ctx,
    input  wire mpsp_pkg::t_hdr_cfg       i_cfg,
    output logic [7:0]                    o_byte
);

    logic [32:0] t;
    assign t = i_ctx.t;

    always_comb begin
        case (i_idx)
            // pack header
            6'd2:  o_byte = mpsp_pkg::START_PREFIX;
            6'd3:  o_byte = mpsp_pkg::PACK_ID;
            6'd4:  o_byte = {2'b01, t[32:30], 1'b1, t[29:28]};
            6'd5:  o_byte = t[27:20];
            6'd6:  o_byte = {t[19:15], 1'b1, t[14:13]};
            6'd7:  o_byte = t[12:5];
            6'd8:  o_byte = {t[4:0], 3'b100};
            6'd9:  o_byte = mpsp_pkg::MARKER_ONE;
            6'd10: o_byte = i_cfg.mux[21:14];
            6'd11: o_byte = i_cfg.mux[13:6];
            6'd12: o_byte = {i_cfg.mux[5:0], 2'b11};
            6'd13: o_byte = mpsp_pkg::STUFF_LEN;
            6'd14: o_byte = mpsp_pkg::FILL_FF;
            6'd15: o_byte = mpsp_pkg::FILL_FF;
            6'd16: o_byte = i_cfg.stuff[31:24];
            6'd17: o_byte = i_cfg.stuff[23:16];
            6'd18: o_byte = i_cfg.stuff[15:8];
            6'd19: o_byte = i_cfg.stuff[7:0];
            // stream map
            6'd22: o_byte = mpsp_pkg::START_PREFIX;
            6'd23: o_byte = mpsp_pkg::MAP_ID;
            6'd25: o_byte = mpsp_pkg::MAP_LEN_LO;
            6'd26: o_byte = mpsp_pkg::MAP_VER;
            6'd27: o_byte = mpsp_pkg::FILL_FF;
            6'd31: o_byte = mpsp_pkg::MAP_INFO_LO;
            6'd32: o_byte = mpsp_pkg::MAP_ES_H264;
            6'd33: o_byte = mpsp_pkg::VIDEO_ID;
            6'd36: o_byte = mpsp_pkg::MAP_ES_AAC;
            6'd37: o_byte = mpsp_pkg::AUDIO_ID;
            6'd40: o_byte = i_cfg.crc[31:24];
            6'd41: o_byte = i_cfg.crc[23:16];
            6'd42: o_byte = i_cfg.crc[15:8];
            6'd43: o_byte = i_cfg.crc[7:0];
            // PES header
            6'd46: o_byte = mpsp_pkg::START_PREFIX;
            6'd47: o_byte = i_ctx.audio ? mpsp_pkg::AUDIO_ID : mpsp_pkg::VIDEO_ID;
            6'd48: o_byte = i_ctx.plen[15:8];
            6'd49: o_byte = i_ctx.plen[7:0];
            6'd50: o_byte = mpsp_pkg::PES_FLAGS1;
            6'd51: o_byte = mpsp_pkg::PES_FLAGS2;
            6'd52: o_byte = mpsp_pkg::PES_HDR_LEN;
            6'd53: o_byte = {4'b0010, t[32:30], 1'b1};
            6'd54: o_byte = t[29:22];
            6'd55: o_byte = {t[21:15], 1'b1};
            6'd56: o_byte = t[14:7];
            6'd57: o_byte = {t[6:0], 1'b1};
            6'd58: o_byte = mpsp_pkg::FILL_FF;
            6'd59: o_byte = mpsp_pkg::FILL_FF;
            6'd60: o_byte = mpsp_pkg::FILL_FF;
            6'd61: o_byte = mpsp_pkg::FILL_FF;
            6'd62: o_byte = mpsp_pkg::FILL_FF;
            6'd63: o_byte = mpsp_pkg::PES_TAIL;
            default: o_byte = 8'h00;
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/mpeg_program_stream_packetizer.sv =====
// Top level of the MPEG-2 program stream packetizer.
`timescale 1ns / 1ps
`default_nettype none

// Wraps one media frame into a program stream packet. A start word (tuser = 0)
// opens a frame and produces the 64-byte header (pack header, stream map, PES
// header) as 64 output words, one per cycle while the output is not stalled,
// tlast on the 64th; a following start word is taken on the cycle of the
// previous header's last byte. Payload words (tuser = 1) pass through at one
// word per cycle while the output is not stalled, held in the input register
// and then the output register; a payload word waits behind a header that
// is still being sent. The frame's final byte carries tuser[0] (end of frame);
// a zero-length frame marks the last header byte instead. A payload word that
// arrives with nothing outstanding is dropped and answered by a single zero
// word with tuser[1] (error) set. Config writes are accepted every cycle; the
// mux rate derived from register 0 is registered from the stored rate, so write
// configuration only while the stream is idle. A start word that arrives
// before the previous frame is complete abandons it.
module mpeg_program_stream_packetizer (
    input  wire         i_clk,
    input  wire         i_rst_n,
    // input stream
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [63:0] s_axis_tdata,  // [15:0] frame_length, [47:16] timestamp_ms,
                                       // [48] is_audio, [56:49] payload_byte, [63:57] 0
    input  wire  [0:0]  s_axis_tuser,  // [0] op
    // output stream
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [7:0]  m_axis_tdata,  // [7:0] out_byte
    output logic        m_axis_tlast,  // last_of_run
    output logic [1:0]  m_axis_tuser,  // [0] end_of_frame, [1] error
    // configuration write channel
    input  wire         i_cfg_valid,
    output logic        o_cfg_ready,
    input  wire  [1:0]  i_cfg_index,
    input  wire  [31:0] i_cfg_data
);

    localparam int IW = mpsp_pkg::HDR_IDX_W;

    // configuration registers
    logic [mpsp_pkg::RATE_W-1:0] r_rate;
    logic [31:0]                 r_stuff;
    logic [31:0]                 r_crc;
    logic [mpsp_pkg::MUX_W-1:0]  r_mux, n_mux;

    // input register
    logic                        r_a_valid;
    logic                        r_a_op;
    logic [mpsp_pkg::LEN_W-1:0]  r_a_len;
    logic [31:0]                 r_a_ms;
    logic                        r_a_audio;
    logic [7:0]                  r_a_byte;

    // header sequencer
    logic                        r_busy, n_busy;
    logic [IW-1:0]               r_idx, n_idx;
    mpsp_pkg::t_hdr_ctx          r_ctx, n_ctx;
    logic                        r_ctx_len0;
    logic [mpsp_pkg::REM_W-1:0]  r_rem, n_rem;

    // output register
    logic                        r_o_valid, n_o_valid;
    logic [7:0]                  r_o_byte, n_o_byte;
    logic                        r_o_last, n_o_last;
    logic                        r_o_eof, n_o_eof;
    logic                        r_o_err, n_o_err;

    logic                        s_fire;
    logic                        gen_ready;
    logic                        hdr_fire;
    logic                        hdr_done;
    logic                        ctx_load;
    logic                        pay_fire;
    logic [7:0]                  hdr_byte;
    mpsp_pkg::t_hdr_cfg          hdr_cfg;

    logic [mpsp_pkg::MUX_NUM_W-1:0] mux_num;
    logic [56:0]                    mux_prod;
    logic [38:0]                    t_full;

    // ---------------- configuration ----------------
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rate  <= '0;
            r_stuff <= '0;
            r_crc   <= '0;
            r_mux   <= '0;
        end else begin
            r_mux <= n_mux;
            if (i_cfg_valid) begin
                case (mpsp_pkg::t_cfg_reg'(i_cfg_index))
                    mpsp_pkg::CFG_RATE:  r_rate  <= i_cfg_data[mpsp_pkg::RATE_W-1:0];
                    mpsp_pkg::CFG_STUFF: r_stuff <= i_cfg_data;
                    mpsp_pkg::CFG_CRC:   r_crc   <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // ceil(rate*1024/50) via reciprocal multiply, registered
    assign mux_num  = {r_rate, 10'd0} + mpsp_pkg::MUX_ROUND;
    assign mux_prod = {29'd0, mux_num} * {28'd0, mpsp_pkg::MUX_RECIP};
    assign n_mux    = mux_prod[mpsp_pkg::MUX_SHIFT +: mpsp_pkg::MUX_W];

    assign hdr_cfg.mux   = r_mux;
    assign hdr_cfg.stuff = r_stuff;
    assign hdr_cfg.crc   = r_crc;

    // ---------------- handshakes ----------------
    assign gen_ready = !r_o_valid || m_axis_tready;
    assign hdr_fire  = r_busy && gen_ready;
    assign hdr_done  = hdr_fire && (r_idx == mpsp_pkg::HDR_LAST);
    // a start word loads the context when no header is in progress, or on the cycle the previous header finishes
    assign ctx_load  = r_a_valid && (r_a_op == mpsp_pkg::OP_START) && (!r_busy || hdr_done);
    assign pay_fire  = r_a_valid && (r_a_op == mpsp_pkg::OP_PAYLOAD) && !r_busy && gen_ready;
    assign s_axis_tready = !r_a_valid || ctx_load || pay_fire;
    assign s_fire        = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_a_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_fire) begin
            r_a_op    <= s_axis_tuser[0];
            r_a_len   <= s_axis_tdata[15:0];
            r_a_ms    <= s_axis_tdata[47:16];
            r_a_audio <= s_axis_tdata[48];
            r_a_byte  <= s_axis_tdata[56:49];
        end
    end

    // ---------------- header context ----------------
    assign t_full = {7'd0, r_a_ms} * {32'd0, mpsp_pkg::SCR_MUL};

    always_comb begin
        n_ctx.t     = t_full[mpsp_pkg::SCR_W-1:0];
        n_ctx.plen  = r_a_len + mpsp_pkg::PES_LEN_ADJ;
        n_ctx.audio = r_a_audio;
    end

    always_ff @(posedge i_clk) begin
        if (ctx_load) begin
            r_ctx      <= n_ctx;
            r_ctx_len0 <= (r_a_len == '0);
        end
    end

    mpsp_hdr_gen u_hdr_gen (
        .i_idx  (r_idx),
        .i_ctx  (r_ctx),
        .i_cfg  (hdr_cfg),
        .o_byte (hdr_byte)
    );

    // ---------------- sequencer and result ----------------
    always_comb begin
        n_busy    = r_busy;
        n_idx     = r_idx;
        n_rem     = r_rem;
        n_o_valid = gen_ready ? 1'b0 : r_o_valid;
        n_o_byte  = r_o_byte;
        n_o_last  = r_o_last;
        n_o_eof   = r_o_eof;
        n_o_err   = r_o_err;

        if (hdr_fire) begin
            n_o_valid = 1'b1;
            n_o_byte  = hdr_byte;
            n_o_last  = (r_idx == mpsp_pkg::HDR_LAST);
            n_o_eof   = (r_idx == mpsp_pkg::HDR_LAST) && r_ctx_len0;
            n_o_err   = 1'b0;
            n_idx     = r_idx + IW'(1);
            if (r_idx == mpsp_pkg::HDR_LAST) begin
                n_busy = 1'b0;
            end
        end

        if (pay_fire) begin
            n_o_valid = 1'b1;
            n_o_last  = 1'b1;
            if (r_rem == '0) begin
                // stray byte: dropped, flagged
                n_o_byte = 8'h00;
                n_o_eof  = 1'b0;
                n_o_err  = 1'b1;
            end else begin
                n_o_byte = r_a_byte;
                n_o_eof  = (r_rem == mpsp_pkg::REM_W'(1));
                n_o_err  = 1'b0;
                n_rem    = r_rem - mpsp_pkg::REM_W'(1);
            end
        end

        if (ctx_load) begin
            n_busy = 1'b1;
            n_idx  = '0;
            n_rem  = {1'b0, r_a_len};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b0;
            r_idx     <= '0;
            r_rem     <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_busy    <= n_busy;
            r_idx     <= n_idx;
            r_rem     <= n_rem;
            r_o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_o_byte <= n_o_byte;
        r_o_last <= n_o_last;
        r_o_eof  <= n_o_eof;
        r_o_err  <= n_o_err;
    end

    assign m_axis_tvalid   = r_o_valid;
    assign m_axis_tdata    = r_o_byte;
    assign m_axis_tlast    = r_o_last;
    assign m_axis_tuser[0] = r_o_eof;
    assign m_axis_tuser[1] = r_o_err;

`ifndef NO_ASSERTIONS
    // loading a frame always restarts the header from its first byte
    a_ctx_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctx_load |=> (r_busy && r_idx == '0))
        else $error("header sequencer did not restart on frame start");

    // payload words never overtake a header in progress
    a_pay_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pay_fire |-> (!r_busy && !hdr_fire))
        else $error("payload word emitted during header");

    // a passed payload byte consumes exactly one count
    a_rem_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pay_fire && r_rem != '0 && !ctx_load) |=>
            (r_rem == $past(r_rem) - mpsp_pkg::REM_W'(1)))
        else $error("remaining count not decremented");
`endif

endmodule

`default_nettype wire
